[rtl/core/cles_pkg.sv]
package cles_pkg;

    // Default coordinate width (columns and rows)
    localparam int COORD_BITS_DEF = 8;

    // Fixed widths
    localparam int PIX_BITS       = 8;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 5;
    localparam int REG_IDX_BITS   = 3;

    // Register reset values
    localparam int RST_BAND_LOW       = 0;
    localparam int RST_BAND_HIGH      = 255;
    localparam int RST_LINE_WIDTH     = 188;
    localparam int RST_SPLIT_COLUMN   = 94;
    localparam int RST_RIGHT_LIMIT    = 188;
    localparam int RST_FIRST_SCAN_ROW = 49;
    localparam int RST_LAST_SCAN_ROW  = 79;
    localparam int RST_TOP_SEARCH_ROW = 100;

    // Register map, one 32-bit word each
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_BAND_LOW       = 3'd0,
        REG_BAND_HIGH      = 3'd1,
        REG_LINE_WIDTH     = 3'd2,
        REG_SPLIT_COLUMN   = 3'd3,
        REG_RIGHT_LIMIT    = 3'd4,
        REG_FIRST_SCAN_ROW = 3'd5,
        REG_LAST_SCAN_ROW  = 3'd6,
        REG_TOP_SEARCH_ROW = 3'd7
    } t_reg_idx;

    // Pixel after the band compare
    typedef struct packed {
        logic marked;
        logic frame_start;
        logic frame_end;
    } t_pix_item;

endpackage

[rtl/core/cles_if.sv]
// Pixel stream channel
interface cles_in_if;
    logic                          valid;
    logic                          ready;
    logic [cles_pkg::PIX_BITS-1:0] pixel;
    logic                          frame_start;
    logic                          frame_end;

    modport source (output valid, output pixel, output frame_start, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel, input frame_start, input frame_end,
                    output ready);
endinterface

// Edge result channel
interface cles_out_if #(
    parameter int COORD_BITS = cles_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  row_valid;
    logic [COORD_BITS-1:0] row_number;
    logic [COORD_BITS-1:0] left_edge;
    logic [COORD_BITS-1:0] right_edge;
    logic [COORD_BITS-1:0] center_column;
    logic                  top_valid;
    logic [COORD_BITS-1:0] top_point;

    modport source (output valid, output row_valid, output row_number, output left_edge,
                    output right_edge, output center_column, output top_valid,
                    output top_point, input ready);
    modport sink   (input valid, input row_valid, input row_number, input left_edge,
                    input right_edge, input center_column, input top_valid,
                    input top_point, output ready);
endinterface

[rtl/core/cles_cfg.sv]
module cles_cfg #(
    parameter int COORD_BITS = cles_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cles_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cles_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cles_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [cles_pkg::PIX_BITS-1:0]       o_band_low,
    output logic [cles_pkg::PIX_BITS-1:0]       o_band_high,
    output logic [COORD_BITS-1:0]               o_line_width,
    output logic [COORD_BITS-1:0]               o_split_column,
    output logic [COORD_BITS-1:0]               o_right_limit,
    output logic [COORD_BITS-1:0]               o_first_scan_row,
    output logic [COORD_BITS-1:0]               o_last_scan_row,
    output logic [COORD_BITS-1:0]               o_top_search_row
);
    import cles_pkg::*;

    logic [PIX_BITS-1:0]   r_band_low;
    logic [PIX_BITS-1:0]   r_band_high;
    logic [COORD_BITS-1:0] r_line_width;
    logic [COORD_BITS-1:0] r_split_column;
    logic [COORD_BITS-1:0] r_right_limit;
    logic [COORD_BITS-1:0] r_first_scan_row;
    logic [COORD_BITS-1:0] r_last_scan_row;
    logic [COORD_BITS-1:0] r_top_search_row;

    logic     wr_en;
    t_reg_idx reg_idx;

    // Word index; the two byte-offset bits are ignored
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low       <= PIX_BITS'(RST_BAND_LOW);
            r_band_high      <= PIX_BITS'(RST_BAND_HIGH);
            r_line_width     <= COORD_BITS'(RST_LINE_WIDTH);
            r_split_column   <= COORD_BITS'(RST_SPLIT_COLUMN);
            r_right_limit    <= COORD_BITS'(RST_RIGHT_LIMIT);
            r_first_scan_row <= COORD_BITS'(RST_FIRST_SCAN_ROW);
            r_last_scan_row  <= COORD_BITS'(RST_LAST_SCAN_ROW);
            r_top_search_row <= COORD_BITS'(RST_TOP_SEARCH_ROW);
        end else if (wr_en) begin
            case (reg_idx)
                REG_BAND_LOW:       r_band_low       <= pwdata[PIX_BITS-1:0];
                REG_BAND_HIGH:      r_band_high      <= pwdata[PIX_BITS-1:0];
                REG_LINE_WIDTH:     r_line_width     <= pwdata[COORD_BITS-1:0];
                REG_SPLIT_COLUMN:   r_split_column   <= pwdata[COORD_BITS-1:0];
                REG_RIGHT_LIMIT:    r_right_limit    <= pwdata[COORD_BITS-1:0];
                REG_FIRST_SCAN_ROW: r_first_scan_row <= pwdata[COORD_BITS-1:0];
                REG_LAST_SCAN_ROW:  r_last_scan_row  <= pwdata[COORD_BITS-1:0];
                REG_TOP_SEARCH_ROW: r_top_search_row <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_BAND_LOW:       prdata = APB_DATA_BITS'(r_band_low);
            REG_BAND_HIGH:      prdata = APB_DATA_BITS'(r_band_high);
            REG_LINE_WIDTH:     prdata = APB_DATA_BITS'(r_line_width);
            REG_SPLIT_COLUMN:   prdata = APB_DATA_BITS'(r_split_column);
            REG_RIGHT_LIMIT:    prdata = APB_DATA_BITS'(r_right_limit);
            REG_FIRST_SCAN_ROW: prdata = APB_DATA_BITS'(r_first_scan_row);
            REG_LAST_SCAN_ROW:  prdata = APB_DATA_BITS'(r_last_scan_row);
            REG_TOP_SEARCH_ROW: prdata = APB_DATA_BITS'(r_top_search_row);
            default:            prdata = '0;
        endcase
    end

    assign o_band_low       = r_band_low;
    assign o_band_high      = r_band_high;
    assign o_line_width     = r_line_width;
    assign o_split_column   = r_split_column;
    assign o_right_limit    = r_right_limit;
    assign o_first_scan_row = r_first_scan_row;
    assign o_last_scan_row  = r_last_scan_row;
    assign o_top_search_row = r_top_search_row;

endmodule

[rtl/core/cles_pix_stage.sv]
module cles_pix_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cles_pkg::PIX_BITS-1:0] i_pixel,
    input  logic                          i_frame_start,
    input  logic                          i_frame_end,
    input  logic [cles_pkg::PIX_BITS-1:0] i_band_low,
    input  logic [cles_pkg::PIX_BITS-1:0] i_band_high,
    input  logic                          i_take,
    output logic                          o_ready,
    output logic                          o_valid,
    output cles_pkg::t_pix_item           o_item
);
    import cles_pkg::*;

    logic      r_valid;
    t_pix_item r_item;
    t_pix_item n_item;
    logic      load;

    // Input register is free when empty or being drained this cycle
    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    // Intensity band test
    always_comb begin
        n_item.marked      = (i_pixel >= i_band_low) && (i_pixel <= i_band_high);
        n_item.frame_start = i_frame_start;
        n_item.frame_end   = i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Drain only happens from a full register
    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_valid)
        else $error("pixel stage drained while empty");

    // A loaded pixel is held in the register, not lost
    a_load_keeps_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_valid)
        else $error("loaded pixel lost");

    // No load while holding an item that is not drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |-> !load)
        else $error("pixel register overwritten");

endmodule

[rtl/core/cles_scan.sv]
module cles_scan #(
    parameter int COORD_BITS = cles_pkg::COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_item_valid,
    input  cles_pkg::t_pix_item    i_item,
    input  logic [COORD_BITS-1:0]  i_line_width,
    input  logic [COORD_BITS-1:0]  i_split_column,
    input  logic [COORD_BITS-1:0]  i_right_limit,
    input  logic [COORD_BITS-1:0]  i_first_scan_row,
    input  logic [COORD_BITS-1:0]  i_last_scan_row,
    input  logic [COORD_BITS-1:0]  i_top_search_row,
    input  logic                   i_out_ready,
    output logic                   o_take,
    output logic                   o_out_valid,
    output logic                   o_row_valid,
    output logic [COORD_BITS-1:0]  o_row_number,
    output logic [COORD_BITS-1:0]  o_left_edge,
    output logic [COORD_BITS-1:0]  o_right_edge,
    output logic [COORD_BITS-1:0]  o_center_column,
    output logic                   o_top_valid,
    output logic [COORD_BITS-1:0]  o_top_point
);
    import cles_pkg::*;

    // Scan state
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_left, n_left;
    logic [COORD_BITS-1:0] r_rfound, n_rfound;
    logic                  r_rseen, n_rseen;
    logic [COORD_BITS-1:0] r_top, n_top;

    // Result register
    logic                  r_out_valid;
    logic                  r_row_valid, n_row_valid;
    logic [COORD_BITS-1:0] r_row_number, n_row_number;
    logic [COORD_BITS-1:0] r_left_edge, n_left_edge;
    logic [COORD_BITS-1:0] r_right_edge, n_right_edge;
    logic [COORD_BITS-1:0] r_center, n_center;
    logic                  r_top_valid, n_top_valid;
    logic [COORD_BITS-1:0] r_top_point, n_top_point;

    logic [COORD_BITS-1:0] x, y, left0, top0;
    logic                  rseen0;
    logic                  in_line;
    logic [COORD_BITS:0]   x_inc;
    logic                  row_end;
    logic                  emit_row;
    logic [COORD_BITS-1:0] left1, rfound1, top1, right_out;
    logic                  rseen1;
    logic [COORD_BITS:0]   edge_sum;

    // Advance when the result register can take a transaction
    assign o_take = i_item_valid && (!r_out_valid || i_out_ready);

    // Per-pixel scan step
    always_comb begin
        // Frame start clears position, edges and top point first
        x      = i_item.frame_start ? '0   : r_col;
        y      = i_item.frame_start ? '0   : r_row;
        left0  = i_item.frame_start ? '0   : r_left;
        rseen0 = i_item.frame_start ? 1'b0 : r_rseen;
        top0   = i_item.frame_start ? '0   : r_top;

        in_line = i_item.marked && (x < i_line_width);

        left1   = left0;
        rfound1 = r_rfound;
        rseen1  = rseen0;
        top1    = top0;
        if (in_line) begin
            if (x < i_split_column) begin
                left1 = x;
            end else if ((x < i_right_limit) && !rseen0) begin
                rfound1 = x;
                rseen1  = 1'b1;
            end
            if ((x == i_split_column) && (y != '0) && (y <= i_top_search_row)) begin
                top1 = y;
            end
        end

        x_inc     = {1'b0, x} + (COORD_BITS+1)'(1);
        row_end   = x_inc >= {1'b0, i_line_width};
        emit_row  = row_end && (y >= i_first_scan_row) && (y <= i_last_scan_row);
        right_out = rseen1 ? rfound1 : i_right_limit;
        edge_sum  = {1'b0, left1} + {1'b0, right_out};

        // Result fields
        n_row_valid  = emit_row;
        n_row_number = emit_row ? y : '0;
        n_left_edge  = emit_row ? left1 : '0;
        n_right_edge = emit_row ? right_out : '0;
        n_center     = emit_row ? edge_sum[COORD_BITS:1] : '0;
        n_top_valid  = i_item.frame_end;
        n_top_point  = i_item.frame_end ? top1 : '0;

        // Next state
        n_rfound = rfound1;
        n_top    = top1;
        if (row_end) begin
            n_col   = '0;
            n_row   = y + COORD_BITS'(1);
            n_left  = '0;
            n_rseen = 1'b0;
        end else begin
            n_col   = x_inc[COORD_BITS-1:0];
            n_row   = y;
            n_left  = left1;
            n_rseen = rseen1;
        end
        if (i_item.frame_end) begin
            n_col   = '0;
            n_row   = '0;
            n_left  = '0;
            n_rseen = 1'b0;
            n_top   = '0;
        end
    end

    // Scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_left  <= '0;
            r_rseen <= 1'b0;
            r_top   <= '0;
        end else if (o_take) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_left  <= n_left;
            r_rseen <= n_rseen;
            r_top   <= n_top;
        end
    end

    // Right edge is only read while right_seen is set
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rfound <= n_rfound;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && (n_row_valid || n_top_valid)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take && (n_row_valid || n_top_valid)) begin
            r_row_valid  <= n_row_valid;
            r_row_number <= n_row_number;
            r_left_edge  <= n_left_edge;
            r_right_edge <= n_right_edge;
            r_center     <= n_center;
            r_top_valid  <= n_top_valid;
            r_top_point  <= n_top_point;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_row_valid     = r_row_valid;
    assign o_row_number    = r_row_number;
    assign o_left_edge     = r_left_edge;
    assign o_right_edge    = r_right_edge;
    assign o_center_column = r_center;
    assign o_top_valid     = r_top_valid;
    assign o_top_point     = r_top_point;

    // Every delivered result carries a row or a top point
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_row_valid || r_top_valid))
        else $error("empty result transaction");

    // Frame end leaves the position at the frame origin
    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.frame_end) |=> (r_col == '0 && r_row == '0 && r_top == '0))
        else $error("frame state not cleared after frame end");

    // A pending result is never overwritten by the scan step
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_take)
        else $error("scan advanced over a stalled result");

endmodule

[rtl/core/center_line_edge_scan_unit.sv]
// Channel   Dir   Handshake          Payload
// i_pix     in    valid/ready        pixel, frame_start, frame_end
// o_res     out   valid/ready        row_valid, row_number, left_edge, right_edge,
//                                    center_column, top_valid, top_point
// APB       in    psel/penable/pready  8 registers at byte address 4*i
//
// One pixel per clock while o_res is not stalled; a pixel's result passes the input register,
// then the result register, before it is valid on o_res.
// The scan step is a compare/update between the two registers, no loops.
// Reset (i_rst_n low, synchronous) clears positions, the left edge, the right-edge flag and
// the top point and loads the register defaults; no clearing pass.
// A stalled output holds one result and one further pixel in the input register.
module center_line_edge_scan_unit #(
    parameter int COORD_BITS = cles_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cles_in_if.sink                            i_pix,
    cles_out_if.source                         o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cles_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [cles_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [cles_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import cles_pkg::*;

    logic [PIX_BITS-1:0]   band_low;
    logic [PIX_BITS-1:0]   band_high;
    logic [COORD_BITS-1:0] line_width;
    logic [COORD_BITS-1:0] split_column;
    logic [COORD_BITS-1:0] right_limit;
    logic [COORD_BITS-1:0] first_scan_row;
    logic [COORD_BITS-1:0] last_scan_row;
    logic [COORD_BITS-1:0] top_search_row;

    logic      item_valid;
    t_pix_item item;
    logic      take;

    // Configuration registers
    cles_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_band_low       (band_low),
        .o_band_high      (band_high),
        .o_line_width     (line_width),
        .o_split_column   (split_column),
        .o_right_limit    (right_limit),
        .o_first_scan_row (first_scan_row),
        .o_last_scan_row  (last_scan_row),
        .o_top_search_row (top_search_row)
    );

    // Input register with band compare
    cles_pix_stage u_pix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_pix.valid),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_frame_end   (i_pix.frame_end),
        .i_band_low    (band_low),
        .i_band_high   (band_high),
        .i_take        (take),
        .o_ready       (i_pix.ready),
        .o_valid       (item_valid),
        .o_item        (item)
    );

    // Edge scan and result register
    cles_scan #(
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_valid),
        .i_item           (item),
        .i_line_width     (line_width),
        .i_split_column   (split_column),
        .i_right_limit    (right_limit),
        .i_first_scan_row (first_scan_row),
        .i_last_scan_row  (last_scan_row),
        .i_top_search_row (top_search_row),
        .i_out_ready      (o_res.ready),
        .o_take           (take),
        .o_out_valid      (o_res.valid),
        .o_row_valid      (o_res.row_valid),
        .o_row_number     (o_res.row_number),
        .o_left_edge      (o_res.left_edge),
        .o_right_edge     (o_res.right_edge),
        .o_center_column  (o_res.center_column),
        .o_top_valid      (o_res.top_valid),
        .o_top_point      (o_res.top_point)
    );

endmodule

[tb/center_line_edge_scan_unit_tb.sv]
`timescale 1ns / 1ps

module center_line_edge_scan_unit_tb;
    import cles_pkg::*;

    localparam int CW            = COORD_BITS_DEF;
    localparam int CLK_PERIOD    = 4;
    localparam int TIMEOUT_NS    = 4_000_000;
    localparam int RANDOM_PIXELS = 600;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int NUM_REGS      = 1 << REG_IDX_BITS;

    typedef logic [CW-1:0] t_coord;

    typedef struct packed {
        logic   row_valid;
        t_coord row_number;
        t_coord left_edge;
        t_coord right_edge;
        t_coord center_column;
        logic   top_valid;
        t_coord top_point;
    } t_scan_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    cles_in_if                     pix_if ();
    cles_out_if #(.COORD_BITS(CW)) res_if ();

    center_line_edge_scan_unit #(.COORD_BITS(CW)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the register file and of the scan state
    logic [7:0]   scan_regs [NUM_REGS];
    t_coord       col_pos;
    t_coord       row_pos;
    t_coord       left_col;
    t_coord       right_col;
    logic         right_hit;
    t_coord       top_row_hit;
    t_scan_result edge_expect_q [$];

    int fail_count     = 0;
    int rand_sent      = 0;
    bit tx_gaps_on     = 1'b1;
    bit rx_gaps_on     = 1'b1;
    int rx_hold_cycles = 0;

    function automatic void check_value(string what, logic [31:0] expected,
                                        logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, expected, actual);
            fail_count++;
        end
    endfunction

    function automatic void clear_scan_row();
        left_col  = '0;
        right_col = scan_regs[REG_RIGHT_LIMIT];
        right_hit = 1'b0;
    endfunction

    function automatic void clear_scan_frame();
        col_pos     = '0;
        row_pos     = '0;
        top_row_hit = '0;
        clear_scan_row();
    endfunction

    function automatic void reset_scan_model();
        scan_regs[REG_BAND_LOW]       = 8'(RST_BAND_LOW);
        scan_regs[REG_BAND_HIGH]      = 8'(RST_BAND_HIGH);
        scan_regs[REG_LINE_WIDTH]     = 8'(RST_LINE_WIDTH);
        scan_regs[REG_SPLIT_COLUMN]   = 8'(RST_SPLIT_COLUMN);
        scan_regs[REG_RIGHT_LIMIT]    = 8'(RST_RIGHT_LIMIT);
        scan_regs[REG_FIRST_SCAN_ROW] = 8'(RST_FIRST_SCAN_ROW);
        scan_regs[REG_LAST_SCAN_ROW]  = 8'(RST_LAST_SCAN_ROW);
        scan_regs[REG_TOP_SEARCH_ROW] = 8'(RST_TOP_SEARCH_ROW);
        clear_scan_frame();
    endfunction

    // Edge scan of one pixel; queues the row / top result it produces
    function automatic void predict_scan_pixel(logic [PIX_BITS-1:0] pix, logic fs, logic fe);
        t_scan_result res;
        t_coord       x;
        t_coord       y;
        t_coord       lft;
        t_coord       rgt;
        logic         marked;
        logic         emit;
        logic [CW:0]  sum;
        if (fs) begin
            clear_scan_frame();
        end
        x      = col_pos;
        y      = row_pos;
        marked = (pix >= scan_regs[REG_BAND_LOW]) && (pix <= scan_regs[REG_BAND_HIGH]);
        emit   = 1'b0;
        lft    = '0;
        rgt    = '0;

        // columns at or past the line width are never looked at
        if (marked && x < scan_regs[REG_LINE_WIDTH]) begin
            if (x < scan_regs[REG_SPLIT_COLUMN]) begin
                left_col = x;
            end else if (x < scan_regs[REG_RIGHT_LIMIT] && !right_hit) begin
                right_col = x;
                right_hit = 1'b1;
            end
            if (x == scan_regs[REG_SPLIT_COLUMN] && y >= 1 &&
                y <= scan_regs[REG_TOP_SEARCH_ROW]) begin
                top_row_hit = y;
            end
        end

        // last column of the line closes the row
        if (int'(x) + 1 >= int'(scan_regs[REG_LINE_WIDTH])) begin
            if (y >= scan_regs[REG_FIRST_SCAN_ROW] && y <= scan_regs[REG_LAST_SCAN_ROW]) begin
                emit = 1'b1;
                lft  = left_col;
                rgt  = right_hit ? right_col : scan_regs[REG_RIGHT_LIMIT];
            end
            col_pos = '0;
            row_pos = y + 1'b1;
            clear_scan_row();
        end else begin
            col_pos = x + 1'b1;
        end

        if (emit || fe) begin
            res = '0;
            if (emit) begin
                sum               = lft + rgt;
                res.row_valid     = 1'b1;
                res.row_number    = y;
                res.left_edge     = lft;
                res.right_edge    = rgt;
                res.center_column = sum[CW:1];
            end
            if (fe) begin
                res.top_valid = 1'b1;
                res.top_point = top_row_hit;
                clear_scan_frame();
            end
            edge_expect_q.push_back(res);
        end
    endfunction

    // Predict on every pixel transaction
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            predict_scan_pixel(pix_if.pixel, pix_if.frame_start, pix_if.frame_end);
        end
    end

    // Compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_scan_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (edge_expect_q.size() == 0) begin
                $display("%0t: result with nothing expected, row %0d top %0d",
                         $time, res_if.row_number, res_if.top_point);
                fail_count++;
            end else begin
                exp_res = edge_expect_q.pop_front();
                check_value("row_valid", 32'(exp_res.row_valid), 32'(res_if.row_valid));
                check_value("row_number", 32'(exp_res.row_number), 32'(res_if.row_number));
                check_value("left_edge", 32'(exp_res.left_edge), 32'(res_if.left_edge));
                check_value("right_edge", 32'(exp_res.right_edge), 32'(res_if.right_edge));
                check_value("center_column", 32'(exp_res.center_column),
                            32'(res_if.center_column));
                check_value("top_valid", 32'(exp_res.top_valid), 32'(res_if.top_valid));
                check_value("top_point", 32'(exp_res.top_point), 32'(res_if.top_point));
            end
        end
    end

    // Result sink: random stall per transaction, plus one long hold on request
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = rx_gaps_on ? $urandom_range(0, 8) : 0;
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    // One pixel transaction; returns at the accepting edge with valid still high
    task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic fs, input logic fe);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= pix;
        pix_if.frame_start <= fs;
        pix_if.frame_end   <= fe;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // Stop the stream and let every expected result come back
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (edge_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access phase; the bus is left selected for the next access
    task automatic apb_access(input logic wr, input t_reg_idx idx,
                              input logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input t_reg_idx idx);
        logic [APB_DATA_BITS-1:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        check_value(idx.name(), APB_DATA_BITS'(scan_regs[idx]), rdata);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [7:0] value);
        logic [APB_DATA_BITS-1:0] wdata;
        logic [APB_DATA_BITS-1:0] rdata;
        wdata = APB_DATA_BITS'(value);
        // stray upper bits must be dropped by the register
        if ($urandom_range(0, 1) == 1) begin
            wdata[APB_DATA_BITS-1:PIX_BITS] = (APB_DATA_BITS - PIX_BITS)'($urandom);
        end
        apb_access(1'b1, idx, wdata, rdata);
        scan_regs[idx] = value;
        check_register(idx);
    endtask

    task automatic set_scan_config(input logic [7:0] band_lo, input logic [7:0] band_hi,
                                   input t_coord lw, input t_coord split,
                                   input t_coord rlimit, input t_coord row_first,
                                   input t_coord row_last, input t_coord top_row);
        wait_idle();
        write_register(REG_BAND_LOW, band_lo);
        write_register(REG_BAND_HIGH, band_hi);
        write_register(REG_LINE_WIDTH, lw);
        write_register(REG_SPLIT_COLUMN, split);
        write_register(REG_RIGHT_LIMIT, rlimit);
        write_register(REG_FIRST_SCAN_ROW, row_first);
        write_register(REG_LAST_SCAN_ROW, row_last);
        write_register(REG_TOP_SEARCH_ROW, top_row);
        apb_release();
    endtask

    task automatic test_register_defaults();
        for (int i = 0; i < NUM_REGS; i++) begin
            check_register(t_reg_idx'(i));
        end
        apb_release();
    endtask

    // Single-value bands at both ends of the pixel range
    task automatic test_band_extremes();
        set_scan_config(8'd0, 8'd0, 4, 2, 4, 0, 1, 1);
        send_pixel(8'd0, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b1);

        set_scan_config(8'd255, 8'd255, 4, 2, 4, 0, 1, 1);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b1);
    endtask

    task automatic test_special_cases();
        set_scan_config(8'd10, 8'd20, 4, 2, 4, 0, 3, 3);
        // start and end on the same pixel
        send_pixel(8'd15, 1'b1, 1'b1);
        // frame ends inside a row: the partial row is dropped
        send_pixel(8'd15, 1'b1, 1'b0);
        send_pixel(8'd5, 1'b0, 1'b0);
        send_pixel(8'd15, 1'b0, 1'b1);

        // zero line width: each pixel closes a row, none is examined
        set_scan_config(8'd10, 8'd20, 0, 2, 4, 0, 3, 3);
        send_pixel(8'd15, 1'b1, 1'b0);
        send_pixel(8'd15, 1'b0, 1'b0);
        send_pixel(8'd15, 1'b0, 1'b1);

        // right limit below the split and an inverted row band
        set_scan_config(8'd10, 8'd20, 4, 3, 2, 2, 1, 3);
        for (int i = 0; i < 8; i++) begin
            send_pixel(i[0] ? 8'd15 : 8'd30, i == 0, i == 7);
        end
    endtask

    // Widest line, split and right limit at their top values
    task automatic test_wide_row();
        set_scan_config(8'd50, 8'd60, 255, 254, 255, 0, 0, 254);
        for (int i = 0; i < 255; i++) begin
            send_pixel(i >= 253 ? 8'd55 : (i[0] ? 8'd200 : 8'd10), i == 0, i == 254);
        end
    endtask

    // One-pixel rows: a result per pixel fills the block while the sink holds off;
    // the frame runs past the row counter wrap
    task automatic test_backpressure_wrap();
        set_scan_config(8'd100, 8'd200, 1, 0, 255, 0, 254, 254);
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 300; i++) begin
            // sender rests until every row has come back
            if (i == 150) begin
                wait_idle();
            end
            send_pixel(8'($urandom_range(0, 255)), i == 0, i == 299);
        end
        tx_gaps_on = 1'b1;
    endtask

    task automatic run_random_frame();
        int         rows;
        int         total;
        int         cut;
        int         kind;
        logic       fs;
        logic       fe;
        logic [7:0] pix;
        logic [7:0] lo;
        logic [7:0] hi;
        lo    = scan_regs[REG_BAND_LOW];
        hi    = scan_regs[REG_BAND_HIGH];
        rows  = (scan_regs[REG_LINE_WIDTH] > 40) ? 1 : $urandom_range(1, 8);
        total = rows * scan_regs[REG_LINE_WIDTH];
        // mostly clean frames; some cut short, some without start, some with flag noise
        kind  = $urandom_range(0, 9);
        cut   = (kind == 0) ? $urandom_range(0, total - 1) : total - 1;
        for (int i = 0; i <= cut; i++) begin
            fs = (i == 0) && (kind != 1);
            fe = (i == cut);
            if (kind == 2) begin
                fs |= ($urandom_range(0, 15) == 0);
                fe |= ($urandom_range(0, 15) == 0);
            end
            if ($urandom_range(0, 1) == 1 && lo <= hi) begin
                pix = 8'($urandom_range(lo, hi));
            end else begin
                pix = 8'($urandom_range(0, 255));
            end
            send_pixel(pix, fs, fe);
            rand_sent++;
        end
    endtask

    task automatic test_random_frames();
        int     bl;
        int     bh;
        int     lw;
        int     sc;
        int     rl;
        int     fr;
        int     lr;
        int     tr;
        int     frames;
        while (rand_sent < RANDOM_PIXELS) begin
            bl = $urandom_range(0, 200);
            bh = $urandom_range(bl, 255);
            case ($urandom_range(0, 7))
                0: begin bl = 255; bh = 0; end
                1: bl = 0;
                2: bh = 255;
                default: ;
            endcase
            lw = $urandom_range(1, 12);
            case ($urandom_range(0, 15))
                0: lw = 1;
                1: lw = 255;
                2: lw = $urandom_range(13, 40);
                default: ;
            endcase
            sc = $urandom_range(0, lw);
            case ($urandom_range(0, 15))
                0: sc = 1;
                1: sc = 254;
                default: ;
            endcase
            rl = $urandom_range(1, (lw + 1 > 255) ? 255 : lw + 1);
            case ($urandom_range(0, 15))
                0: rl = 1;
                1: rl = 255;
                default: ;
            endcase
            fr = $urandom_range(0, 5);
            lr = $urandom_range(fr, 10);
            case ($urandom_range(0, 11))
                0: begin fr = 6; lr = 2; end
                1: fr = 254;
                2: lr = 254;
                3: fr = 0;
                default: ;
            endcase
            tr = $urandom_range(1, 10);
            case ($urandom_range(0, 15))
                0: tr = 1;
                1: tr = 254;
                default: ;
            endcase
            set_scan_config(8'(bl), 8'(bh), t_coord'(lw), t_coord'(sc), t_coord'(rl),
                            t_coord'(fr), t_coord'(lr), t_coord'(tr));

            // some phases run without any idle cycles
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            frames     = $urandom_range(2, 6);
            repeat (frames) run_random_frame();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel       <= '0;
        pix_if.frame_start <= 1'b0;
        pix_if.frame_end   <= 1'b0;
        reset_scan_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();
        test_band_extremes();
        test_special_cases();
        test_wide_row();
        test_backpressure_wrap();
        test_random_frames();

        // drain, then give the pipeline time to show anything unexpected
        pix_if.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && edge_expect_q.size() != 0; n++) begin
            @(posedge i_clk);
        end
        if (edge_expect_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, edge_expect_q.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
